@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define EBH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define EBH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ebh_pkg.sv @@
// shared widths, defaults and the result record of the element header parser
// no dependencies
package ebh_pkg;

   localparam int ID_BITS      = 32;
   localparam int IDLEN_BITS   = 3;
   localparam int SIZE_BITS    = 56;
   localparam int SIZELEN_BITS = 4;
   localparam int END_BITS     = 57;

   localparam int OFFSET_BITS_DEF    = 48;
   localparam int MAX_ID_BYTES_DEF   = 4;
   localparam int MAX_SIZE_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH        = 2;

   // one decoded header, as handed from the parser to the output side
   typedef struct packed {
      logic [ID_BITS-1:0]      element_id;
      logic [IDLEN_BITS-1:0]   id_length;
      logic [SIZE_BITS-1:0]    data_size;
      logic [SIZELEN_BITS-1:0] size_length;
      logic                    malformed;
   } ebh_rec_type;

endpackage

@@ sv/ebh_if.sv @@
// valid/ready channel interfaces for header words in and decoded results out
// depends on ebh_pkg
interface ebh_req_if #(
   parameter int OFFSET_BITS = ebh_pkg::OFFSET_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [7:0]             header_byte;
   logic [OFFSET_BITS-1:0] element_start;

   modport source (output valid, header_byte, element_start, input ready);
   modport sink   (input valid, header_byte, element_start, output ready);
endinterface

interface ebh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ebh_pkg::ID_BITS-1:0]       element_id;
   logic [ebh_pkg::IDLEN_BITS-1:0]    id_length;
   logic [ebh_pkg::SIZE_BITS-1:0]     data_size;
   logic [ebh_pkg::SIZELEN_BITS-1:0]  size_length;
   logic [ebh_pkg::END_BITS-1:0]      end_offset;
   logic                              malformed;

   modport source (output valid, element_id, id_length, data_size, size_length, end_offset,
                   malformed, input ready);
   modport sink   (input valid, element_id, id_length, data_size, size_length, end_offset,
                   malformed, output ready);
endinterface

@@ sv/ebh_front.sv @@
// front end: takes header words, decodes the id and size vints, pushes records
// depends on ebh_pkg and ebh_if
module ebh_front #(
   parameter int OFFSET_BITS    = ebh_pkg::OFFSET_BITS_DEF,
   parameter int MAX_ID_BYTES   = ebh_pkg::MAX_ID_BYTES_DEF,
   parameter int MAX_SIZE_BYTES = ebh_pkg::MAX_SIZE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ebh_req_if.sink                req_chan,
   input  logic                   q_full,
   output logic                   push,
   output ebh_pkg::ebh_rec_type   push_rec,
   output logic [OFFSET_BITS-1:0] push_start
);

   typedef enum logic [3:0] {
      PH_ID_FIRST = 4'b0001,
      PH_ID_MORE  = 4'b0010,
      PH_SZ_FIRST = 4'b0100,
      PH_SZ_MORE  = 4'b1000
   } phase_type;

   phase_type                           phase_ff, phase_in;
   logic [2:0]                          bytes_left_ff, bytes_left_in;
   logic [ebh_pkg::ID_BITS-1:0]         id_ff, id_in;
   logic [ebh_pkg::IDLEN_BITS-1:0]      id_len_ff, id_len_in;
   logic [ebh_pkg::SIZE_BITS-1:0]       size_ff, size_in;
   logic [ebh_pkg::SIZELEN_BITS-1:0]    size_len_ff, size_len_in;
   logic [OFFSET_BITS-1:0]              start_ff, start_in;

   logic       accept;
   logic [7:0] hb;
   logic [3:0] lz;
   logic [2:0] bl_dec;

   function automatic logic [3:0] lead_zeros(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) n = 4'(7 - i);
      end
      return n;
   endfunction

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign hb             = req_chan.header_byte;
   assign lz             = lead_zeros(hb);
   assign bl_dec         = bytes_left_ff - 3'd1;
   assign push_start     = start_ff;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      id_in         = id_ff;
      id_len_in     = id_len_ff;
      size_in       = size_ff;
      size_len_in   = size_len_ff;
      start_in      = start_ff;
      push          = 1'b0;
      push_rec      = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_ID_FIRST: begin
               start_in = req_chan.element_start;
               if (lz >= 4'(MAX_ID_BYTES)) begin
                  // no marker in range: report the lone byte and start over
                  push                = 1'b1;
                  push_rec.element_id = ebh_pkg::ID_BITS'(hb);
                  push_rec.malformed  = 1'b1;
                  bytes_left_in       = 3'd0;
               end else begin
                  id_in         = ebh_pkg::ID_BITS'(hb);
                  id_len_in     = ebh_pkg::IDLEN_BITS'(lz + 4'd1);
                  bytes_left_in = lz[2:0];
                  phase_in      = (lz == 4'd0) ? PH_SZ_FIRST : PH_ID_MORE;
               end
            end
            PH_ID_MORE: begin
               id_in         = {id_ff[ebh_pkg::ID_BITS-9:0], hb};
               bytes_left_in = bl_dec;
               if (bl_dec == 3'd0) phase_in = PH_SZ_FIRST;
            end
            PH_SZ_FIRST: begin
               if (lz >= 4'(MAX_SIZE_BYTES)) begin
                  push                = 1'b1;
                  push_rec.element_id = id_ff;
                  push_rec.id_length  = id_len_ff;
                  push_rec.malformed  = 1'b1;
                  bytes_left_in       = 3'd0;
                  phase_in            = PH_ID_FIRST;
               end else begin
                  // drop the marker bit
                  size_in       = ebh_pkg::SIZE_BITS'(hb & (8'h7f >> lz));
                  size_len_in   = ebh_pkg::SIZELEN_BITS'(lz + 4'd1);
                  bytes_left_in = lz[2:0];
                  if (lz != 4'd0) begin
                     phase_in = PH_SZ_MORE;
                  end else begin
                     push                 = 1'b1;
                     push_rec.element_id  = id_ff;
                     push_rec.id_length   = id_len_ff;
                     push_rec.data_size   = ebh_pkg::SIZE_BITS'(hb & 8'h7f);
                     push_rec.size_length = ebh_pkg::SIZELEN_BITS'(1);
                     bytes_left_in        = 3'd0;
                     phase_in             = PH_ID_FIRST;
                  end
               end
            end
            PH_SZ_MORE: begin
               size_in       = {size_ff[ebh_pkg::SIZE_BITS-9:0], hb};
               bytes_left_in = bl_dec;
               if (bl_dec == 3'd0) begin
                  push                 = 1'b1;
                  push_rec.element_id  = id_ff;
                  push_rec.id_length   = id_len_ff;
                  push_rec.data_size   = size_in;
                  push_rec.size_length = size_len_ff;
                  phase_in             = PH_ID_FIRST;
               end
            end
            default: begin
               phase_in      = PH_ID_FIRST;
               bytes_left_in = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ID_FIRST;
         bytes_left_ff <= 3'd0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      id_len_ff   <= id_len_in;
      size_ff     <= size_in;
      size_len_ff <= size_len_in;
      start_ff    <= start_in;
   end

endmodule

@@ sv/ebh_queue.sv @@
// short record queue between the decoder and the output side
// depends on ebh_pkg
module ebh_queue #(
   parameter int OFFSET_BITS = ebh_pkg::OFFSET_BITS_DEF,
   parameter int DEPTH       = ebh_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ebh_pkg::ebh_rec_type   push_rec,
   input  logic [OFFSET_BITS-1:0] push_start,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output ebh_pkg::ebh_rec_type   head_rec,
   output logic [OFFSET_BITS-1:0] head_start
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ebh_pkg::ebh_rec_type   rec_mem [DEPTH];
   logic [OFFSET_BITS-1:0] start_mem [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = rec_mem[rd_ptr_ff];
   assign head_start = start_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CW'(1);
      if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rec_mem[wr_ptr_ff]   <= push_rec;
         start_mem[wr_ptr_ff] <= push_start;
      end
   end

endmodule

@@ sv/ebh_back.sv @@
// back end: end offset sum and the result output register
// depends on ebh_pkg and ebh_if
module ebh_back #(
   parameter int OFFSET_BITS = ebh_pkg::OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  ebh_pkg::ebh_rec_type   head_rec,
   input  logic [OFFSET_BITS-1:0] head_start,
   output logic                   pop,
   ebh_rsp_if.source              rsp_chan
);

   localparam int EB = ebh_pkg::END_BITS;
   localparam int SB = (OFFSET_BITS < EB) ? OFFSET_BITS : EB;

   logic                 valid_ff, valid_in;
   ebh_pkg::ebh_rec_type rec_ff;
   logic [EB-1:0]        end_ff, end_in;

   assign pop = head_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) valid_in = 1'b1;
      else if (rsp_chan.ready) valid_in = 1'b0;
      // malformed records report a zero end offset
      end_in = '0;
      if (!head_rec.malformed) begin
         end_in = EB'(head_start[SB-1:0]) + EB'(head_rec.id_length)
                + EB'(head_rec.size_length) + EB'(head_rec.data_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head_rec;
         end_ff <= end_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.element_id  = rec_ff.element_id;
   assign rsp_chan.id_length   = rec_ff.id_length;
   assign rsp_chan.data_size   = rec_ff.data_size;
   assign rsp_chan.size_length = rec_ff.size_length;
   assign rsp_chan.end_offset  = end_ff;
   assign rsp_chan.malformed   = rec_ff.malformed;

endmodule

@@ sv/ebml_element_header_parser_top.sv @@
// a result is written into the record queue and then into the output register before it is valid on rsp_chan
// throughput: one header word per cycle; req_chan.ready drops only while the
// two-entry record queue is full, which the output register keeps from happening
// unless rsp_chan.ready is held low
// reset: synchronous, clears the decoder phase, the queue and the output valid
module ebml_element_header_parser_top #(
   parameter int OFFSET_BITS    = ebh_pkg::OFFSET_BITS_DEF,
   parameter int MAX_ID_BYTES   = ebh_pkg::MAX_ID_BYTES_DEF,
   parameter int MAX_SIZE_BYTES = ebh_pkg::MAX_SIZE_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ebh_req_if.sink   req_chan,
   ebh_rsp_if.source rsp_chan
);

   logic                   q_full;
   logic                   push;
   ebh_pkg::ebh_rec_type   push_rec;
   logic [OFFSET_BITS-1:0] push_start;
   logic                   pop;
   logic                   head_valid;
   ebh_pkg::ebh_rec_type   head_rec;
   logic [OFFSET_BITS-1:0] head_start;

   ebh_front #(
      .OFFSET_BITS   (OFFSET_BITS),
      .MAX_ID_BYTES  (MAX_ID_BYTES),
      .MAX_SIZE_BYTES(MAX_SIZE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_full    (q_full),
      .push      (push),
      .push_rec  (push_rec),
      .push_start(push_start)
   );

   ebh_queue #(
      .OFFSET_BITS(OFFSET_BITS),
      .DEPTH      (ebh_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .push_start(push_start),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_rec  (head_rec),
      .head_start(head_start)
   );

   ebh_back #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_rec  (head_rec),
      .head_start(head_start),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ sv/ebh_checker.sv @@
// port-level checks on the element header parser, bound to the top level
// depends on ebh_pkg and assert_macros.svh
`include "assert_macros.svh"

module ebh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ebh_pkg::ID_BITS-1:0]      rsp_element_id,
   input logic [ebh_pkg::IDLEN_BITS-1:0]   rsp_id_length,
   input logic [ebh_pkg::SIZE_BITS-1:0]    rsp_data_size,
   input logic [ebh_pkg::SIZELEN_BITS-1:0] rsp_size_length,
   input logic [ebh_pkg::END_BITS-1:0]     rsp_end_offset,
   input logic                             rsp_malformed
);

   // a stalled result stays put
   `EBH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_id) && $stable(rsp_end_offset), "stalled result changed")

   // a bad first word carries no size and no end offset
   `EBH_ASSERT(a_bad_zero, clock, reset, rsp_valid && rsp_malformed |-> rsp_size_length == '0 && rsp_data_size == '0 && rsp_end_offset == '0, "malformed result has size fields")

   // a bad id first word reports only that word
   `EBH_ASSERT(a_bad_id, clock, reset, rsp_valid && rsp_malformed && rsp_id_length == '0 |-> rsp_element_id[ebh_pkg::ID_BITS-1:8] == '0, "malformed id wider than a word")

   // a good header has both lengths set
   `EBH_ASSERT(a_good_len, clock, reset, rsp_valid && !rsp_malformed |-> rsp_id_length != '0 && rsp_size_length != '0, "good result with zero length")

   `EBH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind ebml_element_header_parser_top ebh_checker u_ebh_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_element_id (rsp_chan.element_id),
   .rsp_id_length  (rsp_chan.id_length),
   .rsp_data_size  (rsp_chan.data_size),
   .rsp_size_length(rsp_chan.size_length),
   .rsp_end_offset (rsp_chan.end_offset),
   .rsp_malformed  (rsp_chan.malformed)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the element header parser: byte stream in, decoded headers out
// depends on ebh_pkg, ebh_req_if, ebh_rsp_if and ebml_element_header_parser_top
module tb_top;

   localparam int OFFSET_BITS    = ebh_pkg::OFFSET_BITS_DEF;
   localparam int MAX_ID_BYTES   = ebh_pkg::MAX_ID_BYTES_DEF;
   localparam int MAX_SIZE_BYTES = ebh_pkg::MAX_SIZE_BYTES_DEF;
   localparam int ID_BITS        = ebh_pkg::ID_BITS;
   localparam int IDLEN_BITS     = ebh_pkg::IDLEN_BITS;
   localparam int SIZE_BITS      = ebh_pkg::SIZE_BITS;
   localparam int SIZELEN_BITS   = ebh_pkg::SIZELEN_BITS;
   localparam int END_BITS       = ebh_pkg::END_BITS;
   localparam int RESULT_LATENCY = 2;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_LIMIT     = 3000;

   typedef enum logic [3:0] {
      WAIT_ID_FIRST   = 4'b0001,
      WAIT_ID_REST    = 4'b0010,
      WAIT_SIZE_FIRST = 4'b0100,
      WAIT_SIZE_REST  = 4'b1000
   } parse_phase_type;

   typedef struct {
      logic [ID_BITS-1:0]      element_id;
      logic [IDLEN_BITS-1:0]   id_length;
      logic [SIZE_BITS-1:0]    data_size;
      logic [SIZELEN_BITS-1:0] size_length;
      logic [END_BITS-1:0]     end_offset;
      logic                    malformed;
   } header_result_type;

   logic clock = 1'b0;
   logic reset;

   ebh_req_if #(.OFFSET_BITS(OFFSET_BITS)) req_chan ();
   ebh_rsp_if rsp_chan ();

   ebml_element_header_parser_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state mirrored by the predictor
   parse_phase_type         phase_q;
   logic [2:0]              left_q;
   logic [ID_BITS-1:0]      id_q;
   logic [IDLEN_BITS-1:0]   idlen_q;
   logic [SIZE_BITS-1:0]    size_q;
   logic [SIZELEN_BITS-1:0] sizelen_q;
   logic [OFFSET_BITS-1:0]  start_q;

   header_result_type pending_headers[$];
   int  mismatch_count = 0;
   int  words_sent     = 0;
   bit  hold_request   = 1'b0;
   bit  no_idle        = 1'b0;

   function automatic int lead_zeros(input logic [7:0] b);
      int n;
      n = 0;
      for (int i = 7; i >= 0; i--) begin
         if (b[i]) break;
         n++;
      end
      return n;
   endfunction

   // advance the mirrored decoder by one header word, queue any decoded header
   function automatic void decode_header_byte(input logic [7:0] b,
                                              input logic [OFFSET_BITS-1:0] start);
      int                lz;
      bit                done;
      header_result_type r;
      done = 1'b0;
      r = '{default: '0};
      case (phase_q)
         WAIT_ID_FIRST: begin
            start_q = start;
            lz = lead_zeros(b);
            if (lz >= MAX_ID_BYTES) begin
               r.element_id = ID_BITS'(b);
               r.malformed  = 1'b1;
               left_q = '0;
               pending_headers.push_back(r);
            end else begin
               idlen_q = IDLEN_BITS'(lz + 1);
               id_q    = ID_BITS'(b);
               left_q  = 3'(lz);
               phase_q = (lz == 0) ? WAIT_SIZE_FIRST : WAIT_ID_REST;
            end
         end
         WAIT_ID_REST: begin
            id_q   = {id_q[ID_BITS-9:0], b};
            left_q = left_q - 3'd1;
            if (left_q == 3'd0) phase_q = WAIT_SIZE_FIRST;
         end
         WAIT_SIZE_FIRST: begin
            lz = lead_zeros(b);
            if (lz >= MAX_SIZE_BYTES) begin
               r.element_id = id_q;
               r.id_length  = idlen_q;
               r.malformed  = 1'b1;
               phase_q = WAIT_ID_FIRST;
               left_q  = '0;
               pending_headers.push_back(r);
            end else begin
               sizelen_q = SIZELEN_BITS'(lz + 1);
               size_q    = SIZE_BITS'(b & (8'h7F >> lz));
               left_q    = 3'(lz);
               if (lz != 0) phase_q = WAIT_SIZE_REST;
               else done = 1'b1;
            end
         end
         WAIT_SIZE_REST: begin
            size_q = {size_q[SIZE_BITS-9:0], b};
            left_q = left_q - 3'd1;
            if (left_q == 3'd0) done = 1'b1;
         end
         default: begin
            phase_q = WAIT_ID_FIRST;
         end
      endcase
      if (done) begin
         r.element_id  = id_q;
         r.id_length   = idlen_q;
         r.data_size   = size_q;
         r.size_length = sizelen_q;
         r.end_offset  = END_BITS'(start_q) + END_BITS'(idlen_q) + END_BITS'(sizelen_q)
                         + END_BITS'(size_q);
         phase_q = WAIT_ID_FIRST;
         left_q  = '0;
         pending_headers.push_back(r);
      end
   endfunction

   function automatic logic [OFFSET_BITS-1:0] rand_offset();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return OFFSET_BITS'({$urandom(), $urandom()});
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic send_word(input logic [7:0] b, input logic [OFFSET_BITS-1:0] start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.header_byte   <= b;
      req_chan.element_start <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      decode_header_byte(b, start);
      words_sent++;
   endtask

   task automatic send_element_id(input int idl, input logic [OFFSET_BITS-1:0] start);
      logic [7:0] lead;
      lead = 8'h80 >> (idl - 1);
      lead = lead | (8'($urandom) & (lead - 8'd1));
      send_word(lead, start);
      for (int k = 1; k < idl; k++) send_word(8'($urandom), rand_offset());
   endtask

   task automatic send_element(input int idl, input int szl, input logic [SIZE_BITS-1:0] sz,
                               input logic [OFFSET_BITS-1:0] start);
      logic [63:0] coded;
      send_element_id(idl, start);
      // marker bit on top of the 7 payload bits per size byte
      coded = (64'd1 << (7 * szl)) | (64'(sz) & ((64'd1 << (7 * szl)) - 64'd1));
      for (int k = szl - 1; k >= 0; k--) send_word(coded[8*k +: 8], rand_offset());
   endtask

   task automatic send_bad_size(input int idl, input logic [OFFSET_BITS-1:0] start);
      send_element_id(idl, start);
      send_word(8'h00, rand_offset());
   endtask

   task automatic send_random_element();
      int pick;
      int szl;
      logic [SIZE_BITS-1:0] sz;
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
         send_word(8'($urandom_range(0, 15)), rand_offset());
      end else if (pick < 12) begin
         send_bad_size($urandom_range(1, MAX_ID_BYTES), rand_offset());
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 60) szl = $urandom_range(1, 2);
         else if (pick < 90) szl = $urandom_range(3, 5);
         else szl = $urandom_range(6, MAX_SIZE_BYTES);
         sz = ($urandom_range(0, 19) == 0) ? '1 : SIZE_BITS'({$urandom(), $urandom()});
         send_element($urandom_range(1, MAX_ID_BYTES), szl, sz, rand_offset());
      end
   endtask

   // stop offering words, then wait for every expected result
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (pending_headers.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_element(1, 1, '0, '0);
      send_element(MAX_ID_BYTES, MAX_SIZE_BYTES, '1, '1);
      send_word(8'h00, '1);
      send_word(8'h0F, '0);
      send_bad_size(1, '1);
      // all-ones single byte size, the unknown-size code
      send_element(1, 1, 56'h7F, '0);
      wait_results_drained();
   endtask

   task automatic test_random_stream(input int n_words);
      int target;
      target = words_sent + n_words;
      while (words_sent < target) send_random_element();
      wait_results_drained();
   endtask

   // receiver stalls long enough for the queue to fill and stop the input
   task automatic test_output_hold();
      hold_request = 1'b1;
      repeat (30) send_random_element();
      wait_results_drained();
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (60) send_random_element();
      no_idle = 1'b0;
      wait_results_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.header_byte   <= '0;
      req_chan.element_start <= '0;
      phase_q   = WAIT_ID_FIRST;
      left_q    = '0;
      id_q      = '0;
      idlen_q   = '0;
      size_q    = '0;
      sizelen_q = '0;
      start_q   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stream(1300);
      test_output_hold();
      test_back_to_back();
      repeat (RESULT_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   task automatic check_header_result();
      header_result_type exp_r;
      if (pending_headers.size() == 0) begin
         $error("header result with nothing expected, element_id %0h", rsp_chan.element_id);
         mismatch_count++;
         return;
      end
      exp_r = pending_headers.pop_front();
      check_field("element_id", 64'(exp_r.element_id), 64'(rsp_chan.element_id));
      check_field("id_length", 64'(exp_r.id_length), 64'(rsp_chan.id_length));
      check_field("data_size", 64'(exp_r.data_size), 64'(rsp_chan.data_size));
      check_field("size_length", 64'(exp_r.size_length), 64'(rsp_chan.size_length));
      check_field("end_offset", 64'(exp_r.end_offset), 64'(rsp_chan.end_offset));
      check_field("malformed", 64'(exp_r.malformed), 64'(rsp_chan.malformed));
   endtask

   // result side: check accepted results, then choose ready for the next cycle
   initial begin
      int stall;
      int pick;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_header_result();
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !no_idle && $urandom_range(0, 99) < 20) begin
            pick = $urandom_range(0, 99);
            stall = (pick < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $error("no word moved for %0d cycles, %0d results outstanding",
                   quiet, pending_headers.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
